/* src/gesture_vote_latch_filter_top_defines.svh */
// assertion macros for the gesture vote and latch filter rtl
`ifndef GESTURE_VOTE_LATCH_FILTER_TOP_DEFINES_SVH
`define GESTURE_VOTE_LATCH_FILTER_TOP_DEFINES_SVH

// concurrent assertion on an explicit clock and active-low reset
`define GVLF_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define GVLF_ASSERT(lbl, prop, msg) \
  `GVLF_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* src/gvlf_pkg.sv */
// types, constants and helpers for the gesture vote and latch filter
`timescale 1ns / 1ps

package gvlf_pkg;

  localparam int unsigned ClassW  = 3;
  localparam int unsigned CountW  = 3;
  localparam int unsigned CoolW   = 32;
  localparam int unsigned AbsentW = 8;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned CfgIdxW = 1;

  // gesture class codes
  localparam logic [ClassW-1:0] GestNone  = 3'd0;
  localparam logic [ClassW-1:0] GestFist  = 3'd1;
  localparam logic [ClassW-1:0] GestTwo   = 3'd4;
  localparam logic [ClassW-1:0] GestThree = 3'd5;

  localparam logic [CountW-1:0] VotesLong  = 3'd4;
  localparam logic [CountW-1:0] VotesShort = 3'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxCooldown = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxAbsent   = 1'b1;

  localparam logic [CoolW-1:0]   CooldownRst = 32'd1000;
  localparam logic [AbsentW-1:0] AbsentRst   = 8'd3;
  localparam logic [AbsentW-1:0] AbsentMax   = 8'hFF;

  typedef struct packed {
    logic [CoolW-1:0]   cooldown_ms;
    logic [AbsentW-1:0] absent_frames_needed;
  } gvlf_cfg_t;

  typedef struct packed {
    logic [ClassW-1:0] candidate_class;
    logic [CountW-1:0] confirm_count;
    logic [CountW-1:0] votes_needed;
    logic [ClassW-1:0] triggered_class;
    logic              is_latched;
  } gvlf_result_t;

  function automatic logic [CountW-1:0] votes_for(input logic [ClassW-1:0] g);
    logic [CountW-1:0] v;
    case (g) inside
      GestFist, GestTwo, GestThree: v = VotesLong;
      default:                      v = VotesShort;
    endcase
    return v;
  endfunction

endpackage

/* src/gesture_vote_latch_filter_top.sv */
// top level of the gesture vote and latch filter
`timescale 1ns / 1ps

// gesture vote and latch filter. each input transfer is one camera frame: gesture class,
// hand-present flag and a 64-bit millisecond timestamp. every frame yields exactly one
// result transfer, in order. a class is triggered after a run of equal frames (four for
// fist, two and three, three for the others); the trigger latches the class with its time.
// while latched the block holds until the hand has been absent for absent_frames_needed
// frames and cooldown_ms has passed, or until a different gesture shows after the cooldown.
// timing: a frame waits in the input register, then the whole state update and the
// result are computed combinationally into the output register; one frame is taken
// every cycle while the output is not stalled. the longest path is the 64-bit elapsed-time
// subtract and compare against the cooldown. configuration is to be written through the
// plain write port (index 0 cooldown_ms, index 1 absent_frames_needed) only while no frame
// is in flight; the user is bound to this, the block itself does not enforce it.
module gesture_vote_latch_filter_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [gvlf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gvlf_pkg::CoolW-1:0]   cfg_wdata_i,
  // frame input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gvlf_pkg::ClassW-1:0]  gesture_i,
  input  logic                         hand_present_i,
  input  logic [gvlf_pkg::TimeW-1:0]   now_ms_i,
  // result output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [gvlf_pkg::ClassW-1:0]  candidate_class_o,
  output logic [gvlf_pkg::CountW-1:0]  confirm_count_o,
  output logic [gvlf_pkg::CountW-1:0]  votes_needed_o,
  output logic [gvlf_pkg::ClassW-1:0]  triggered_class_o,
  output logic                         is_latched_o
);
  import gvlf_pkg::*;

  gvlf_cfg_t    cfg;
  gvlf_result_t res;

  // input register
  logic              in_valid_q;
  logic [ClassW-1:0] gesture_q;
  logic              hand_q;
  logic [TimeW-1:0]  now_q;

  // output register
  logic         out_valid_q;
  gvlf_result_t res_q;

  logic out_free;  // output register can take a new result this cycle
  logic in_xfer;   // input transfer completes
  logic item_en;   // frame in the input register is processed

  assign out_free   = !out_valid_q || !out_stall_i;
  assign item_en    = in_valid_q && out_free;
  // input register frees up whenever its frame moves on
  assign in_stall_o = in_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (item_en) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      gesture_q <= gesture_i;
      hand_q    <= hand_present_i;
      now_q     <= now_ms_i;
    end
  end

  gvlf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  gvlf_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_en_i      (item_en),
    .gesture_i      (gesture_q),
    .hand_present_i (hand_q),
    .now_ms_i       (now_q),
    .cfg_i          (cfg),
    .res_o          (res)
  );

  // result register: loads with the frame, drops once the transfer is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_en) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign candidate_class_o = res_q.candidate_class;
  assign confirm_count_o   = res_q.confirm_count;
  assign votes_needed_o    = res_q.votes_needed;
  assign triggered_class_o = res_q.triggered_class;
  assign is_latched_o      = res_q.is_latched;

endmodule

/* src/gvlf_cfg.sv */
// configuration registers of the gesture vote and latch filter
`timescale 1ns / 1ps

module gvlf_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gvlf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gvlf_pkg::CoolW-1:0]   cfg_wdata_i,
  output gvlf_pkg::gvlf_cfg_t          cfg_o
);
  import gvlf_pkg::*;

  gvlf_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxCooldown: cfg_d.cooldown_ms = cfg_wdata_i;
        CfgIdxAbsent:   cfg_d.absent_frames_needed = cfg_wdata_i[AbsentW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cooldown_ms          <= CooldownRst;
      cfg_q.absent_frames_needed <= AbsentRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/gvlf_core.sv */
// vote, latch and release state with the per-frame result logic
`timescale 1ns / 1ps
`include "gesture_vote_latch_filter_top_defines.svh"

module gvlf_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_en_i,
  input  logic [gvlf_pkg::ClassW-1:0] gesture_i,
  input  logic                        hand_present_i,
  input  logic [gvlf_pkg::TimeW-1:0]  now_ms_i,
  input  gvlf_pkg::gvlf_cfg_t         cfg_i,
  output gvlf_pkg::gvlf_result_t      res_o
);
  import gvlf_pkg::*;

  logic [ClassW-1:0]  cand_class_q, cand_class_d;
  logic [CountW-1:0]  run_count_q, run_count_d;
  logic [ClassW-1:0]  held_class_q, held_class_d;
  logic               held_flag_q, held_flag_d;
  logic [AbsentW-1:0] absent_count_q, absent_count_d;
  logic [TimeW-1:0]   trigger_time_q, trigger_time_d;

  logic [TimeW-1:0]   since_trig;
  logic               elapsed;
  logic [AbsentW-1:0] absent_inc;
  logic [AbsentW-1:0] absent_next;
  logic [CountW-1:0]  need;
  logic [CountW-1:0]  run_inc;
  logic               done;
  gvlf_result_t       res;

  assign since_trig  = now_ms_i - trigger_time_q;
  assign elapsed     = since_trig >= {{(TimeW-CoolW){1'b0}}, cfg_i.cooldown_ms};
  assign absent_inc  = (absent_count_q == AbsentMax) ? AbsentMax : absent_count_q + 8'd1;
  assign absent_next = hand_present_i ? '0 :
                       ((absent_inc < cfg_i.absent_frames_needed) ? absent_inc
                                                                  : cfg_i.absent_frames_needed);
  assign need        = votes_for(gesture_i);
  assign run_inc     = run_count_q + 3'd1;

  always_comb begin
    cand_class_d   = cand_class_q;
    run_count_d    = run_count_q;
    held_class_d   = held_class_q;
    held_flag_d    = held_flag_q;
    absent_count_d = absent_count_q;
    trigger_time_d = trigger_time_q;
    res            = '0;
    done           = 1'b0;

    // latched: track absence and decide on hold, release or switch
    if (held_flag_q) begin
      absent_count_d = absent_next;
      cand_class_d   = GestNone;
      run_count_d    = '0;
      if (!hand_present_i) begin
        if (elapsed && (absent_next >= cfg_i.absent_frames_needed)) begin
          held_class_d   = GestNone;
          held_flag_d    = 1'b0;
          absent_count_d = '0;
          trigger_time_d = '0;
        end else begin
          res.is_latched = 1'b1;
          done           = 1'b1;
        end
      end else if (gesture_i == GestNone || gesture_i == held_class_q || !elapsed) begin
        res.candidate_class = gesture_i;
        res.votes_needed    = need;
        res.is_latched      = 1'b1;
        done                = 1'b1;
      end else begin
        held_flag_d    = 1'b0;
        absent_count_d = '0;
      end
    end

    // voting on the frame
    if (!done) begin
      if (gesture_i == GestNone) begin
        cand_class_d = GestNone;
        run_count_d  = '0;
      end else begin
        if (gesture_i != cand_class_d) begin
          cand_class_d = gesture_i;
          run_count_d  = 3'd1;
        end else begin
          run_count_d = (run_inc < need) ? run_inc : need;
        end
        res.candidate_class = cand_class_d;
        res.confirm_count   = run_count_d;
        res.votes_needed    = need;
        if (run_count_d >= need) begin
          held_flag_d         = 1'b1;
          held_class_d        = cand_class_d;
          trigger_time_d      = now_ms_i;
          absent_count_d      = '0;
          res.triggered_class = cand_class_d;
          res.is_latched      = 1'b1;
          cand_class_d        = GestNone;
          run_count_d         = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_class_q   <= GestNone;
      run_count_q    <= '0;
      held_class_q   <= GestNone;
      held_flag_q    <= 1'b0;
      absent_count_q <= '0;
      trigger_time_q <= '0;
    end else if (item_en_i) begin
      cand_class_q   <= cand_class_d;
      run_count_q    <= run_count_d;
      held_class_q   <= held_class_d;
      held_flag_q    <= held_flag_d;
      absent_count_q <= absent_count_d;
      trigger_time_q <= trigger_time_d;
    end
  end

  assign res_o = res;

  `GVLF_ASSERT(a_latched_no_run, held_flag_q |-> (run_count_q == '0), "run count while latched")
  `GVLF_ASSERT(a_cand_run_pair, (cand_class_q == GestNone) == (run_count_q == '0),
               "candidate and run count disagree")
  `GVLF_ASSERT(a_run_below_need, (run_count_q != '0) |-> (run_count_q < votes_for(cand_class_q)),
               "stored run reached its vote count")
  `GVLF_ASSERT(a_trig_latches, (item_en_i && res.triggered_class != GestNone) |-> res.is_latched,
               "trigger without latch")

endmodule

/* verif/gvlf_frame_checker.sv */
// frame checker for the gesture vote and latch filter: predicts each result and compares
`timescale 1ns / 1ps

module gvlf_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gvlf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gvlf_pkg::CoolW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [gvlf_pkg::ClassW-1:0]  gesture_i,
  input  logic                         hand_present_i,
  input  logic [gvlf_pkg::TimeW-1:0]   now_ms_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [gvlf_pkg::ClassW-1:0]  candidate_class_i,
  input  logic [gvlf_pkg::CountW-1:0]  confirm_count_i,
  input  logic [gvlf_pkg::CountW-1:0]  votes_needed_i,
  input  logic [gvlf_pkg::ClassW-1:0]  triggered_class_i,
  input  logic                         is_latched_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           triggers_o
);
  import gvlf_pkg::*;

  // configuration copy
  logic [CoolW-1:0]   cooldown;
  logic [AbsentW-1:0] absent_need;

  // filter state copy
  logic [ClassW-1:0]  cand_cls;
  logic [CountW-1:0]  run_len;
  logic [ClassW-1:0]  held_cls;
  logic               held_on;
  logic [AbsentW-1:0] absent_run;
  logic [TimeW-1:0]   trig_ms;

  gvlf_result_t predicted_results[$];
  gvlf_result_t want;

  function automatic logic [CountW-1:0] run_length_for(input logic [ClassW-1:0] g);
    if (g == GestFist || g == GestTwo || g == GestThree) return VotesLong;
    return VotesShort;
  endfunction

  // one frame through the vote and latch state, returns the result it yields
  function automatic gvlf_result_t filter_frame(input logic [ClassW-1:0] g, input logic hand,
                                                input logic [TimeW-1:0] now);
    gvlf_result_t       r;
    logic               settled;
    logic               elapsed;
    logic [AbsentW-1:0] bumped;
    logic [CountW-1:0]  need;
    r = '0;
    settled = 1'b0;
    if (held_on) begin
      if (hand) begin
        absent_run = '0;
      end else begin
        // saturate at 255 and at the threshold
        bumped = (absent_run == AbsentMax) ? AbsentMax : absent_run + 1'b1;
        absent_run = (bumped < absent_need) ? bumped : absent_need;
      end
      elapsed = (now - trig_ms) >= cooldown;
      cand_cls = GestNone;
      run_len = '0;
      if (!hand) begin
        if (elapsed && absent_run >= absent_need) begin
          // release: back to reset state, frame voted below
          held_cls = GestNone;
          held_on = 1'b0;
          absent_run = '0;
          trig_ms = '0;
        end else begin
          r.is_latched = 1'b1;
          settled = 1'b1;
        end
      end else if (g == GestNone || g == held_cls || !elapsed) begin
        r.candidate_class = g;
        r.votes_needed = run_length_for(g);
        r.is_latched = 1'b1;
        settled = 1'b1;
      end else begin
        // switch to another gesture, held class and time kept
        held_on = 1'b0;
        absent_run = '0;
      end
    end
    if (!settled) begin
      if (g == GestNone) begin
        cand_cls = GestNone;
        run_len = '0;
      end else begin
        need = run_length_for(g);
        if (g != cand_cls) begin
          cand_cls = g;
          run_len = 3'd1;
        end else if (run_len < need) begin
          run_len = run_len + 1'b1;
        end
        r.candidate_class = cand_cls;
        r.confirm_count = run_len;
        r.votes_needed = need;
        if (run_len >= need) begin
          held_on = 1'b1;
          held_cls = cand_cls;
          trig_ms = now;
          absent_run = '0;
          r.triggered_class = cand_cls;
          r.is_latched = 1'b1;
          cand_cls = GestNone;
          run_len = '0;
          triggers_o++;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown = CooldownRst;
      absent_need = AbsentRst;
      cand_cls = GestNone;
      run_len = '0;
      held_cls = GestNone;
      held_on = 1'b0;
      absent_run = '0;
      trig_ms = '0;
      predicted_results.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      triggers_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          $error("result transfer with no frame outstanding (candidate_class %0d)",
                 candidate_class_i);
          fail_count_o++;
        end else begin
          want = predicted_results.pop_front();
          checked_o++;
          if (candidate_class_i !== want.candidate_class) begin
            $error("candidate_class: expected %0d actual %0d", want.candidate_class,
                   candidate_class_i);
            fail_count_o++;
          end
          if (confirm_count_i !== want.confirm_count) begin
            $error("confirm_count: expected %0d actual %0d", want.confirm_count,
                   confirm_count_i);
            fail_count_o++;
          end
          if (votes_needed_i !== want.votes_needed) begin
            $error("votes_needed: expected %0d actual %0d", want.votes_needed,
                   votes_needed_i);
            fail_count_o++;
          end
          if (triggered_class_i !== want.triggered_class) begin
            $error("triggered_class: expected %0d actual %0d", want.triggered_class,
                   triggered_class_i);
            fail_count_o++;
          end
          if (is_latched_i !== want.is_latched) begin
            $error("is_latched: expected %0d actual %0d", want.is_latched, is_latched_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predicted_results.push_back(filter_frame(gesture_i, hand_present_i, now_ms_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgIdxCooldown: cooldown = cfg_wdata_i;
          CfgIdxAbsent:   absent_need = cfg_wdata_i[AbsentW-1:0];
          default: ;
        endcase
      end
      pending_o = predicted_results.size();
    end
  end

endmodule

/* verif/testbench.sv */
// top of the gesture vote and latch filter testbench: stimulus, idling and verdict
`timescale 1ns / 1ps

module testbench;
  import gvlf_pkg::*;

  // class codes the package leaves unnamed
  localparam logic [ClassW-1:0] GestOk    = 3'd2;
  localparam logic [ClassW-1:0] GestFive  = 3'd3;
  localparam logic [ClassW-1:0] GestFour  = 3'd6;
  localparam logic [ClassW-1:0] GestSpare = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CoolW-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ClassW-1:0]   gesture_i;
  logic                hand_present_i;
  logic [TimeW-1:0]    now_ms_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ClassW-1:0]   candidate_class_o;
  logic [CountW-1:0]   confirm_count_o;
  logic [CountW-1:0]   votes_needed_o;
  logic [ClassW-1:0]   triggered_class_o;
  logic                is_latched_o;

  int fail_count;
  int pending;
  int checked;
  int triggers;

  // stimulus knobs
  int                 snd_idle_pct;
  int                 rcv_idle_pct;
  int                 hold_req;
  int                 hold_left;
  int                 frames_sent;
  int                 stop_at;
  int unsigned        step_max;
  logic [TimeW-1:0]   now_t;
  logic [CoolW-1:0]   cur_cool;
  logic [AbsentW-1:0] cur_absent;

  gesture_vote_latch_filter_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .gesture_i         (gesture_i),
    .hand_present_i    (hand_present_i),
    .now_ms_i          (now_ms_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .candidate_class_o (candidate_class_o),
    .confirm_count_o   (confirm_count_o),
    .votes_needed_o    (votes_needed_o),
    .triggered_class_o (triggered_class_o),
    .is_latched_o      (is_latched_o)
  );

  gvlf_frame_checker checker_u (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .gesture_i         (gesture_i),
    .hand_present_i    (hand_present_i),
    .now_ms_i          (now_ms_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .candidate_class_i (candidate_class_o),
    .confirm_count_i   (confirm_count_o),
    .votes_needed_i    (votes_needed_o),
    .triggered_class_i (triggered_class_o),
    .is_latched_i      (is_latched_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .checked_o         (checked),
    .triggers_o        (triggers)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stall, or a long hold-off when one is requested
  initial begin
    out_stall_i = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // one frame transfer; payload held while stalled, returns at the accepting edge
  task automatic send_frame(input logic [ClassW-1:0] g, input logic hand,
                            input logic [TimeW-1:0] now);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    gesture_i <= g;
    hand_present_i <= hand;
    now_ms_i <= now;
    do @(posedge clk_i); while (in_stall_o);
    frames_sent++;
  endtask

  // frame with the clock moving forward a little
  task automatic next_frame(input logic [ClassW-1:0] g, input logic hand);
    now_t += $urandom_range(0, step_max);
    send_frame(g, hand, now_t);
  endtask

  // stop offering and wait until every result has been taken
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // both registers, back to back; called only when idle at a falling edge
  task automatic set_config(input logic [CoolW-1:0] cool, input logic [AbsentW-1:0] absent);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgIdxCooldown;
    cfg_wdata_i <= cool;
    @(negedge clk_i);
    cfg_idx_i <= CfgIdxAbsent;
    cfg_wdata_i <= absent;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cool = cool;
    cur_absent = absent;
  endtask

  function automatic logic [ClassW-1:0] random_class();
    if ($urandom_range(0, 19) == 0) return GestSpare;
    return ClassW'($urandom_range(1, 6));
  endfunction

  // mostly well-formed runs and absences, some noise and time jumps
  task automatic random_burst();
    int                kind;
    int                len;
    int                lim;
    logic [ClassW-1:0] g;
    logic              hand;
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      // run of one gesture, sometimes long enough to trigger
      g = random_class();
      len = $urandom_range(1, 5);
      hand = ($urandom_range(0, 19) != 0);
      repeat (len) next_frame(g, hand);
    end else if (kind <= 6) begin
      // hand gone for a while, sometimes with a class still reported
      lim = cur_absent + 2;
      if (lim > 8) lim = 8;
      len = $urandom_range(1, lim);
      g = ($urandom_range(0, 3) == 0) ? random_class() : GestNone;
      repeat (len) next_frame(g, 1'b0);
    end else if (kind == 7) begin
      next_frame(ClassW'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 2)) next_frame(GestNone, 1'b1);
    end else begin
      // time jumps: far ahead, anywhere, one cooldown ahead, or slightly back (wraps)
      case ($urandom_range(0, 3))
        0: now_t += {$urandom, $urandom};
        1: now_t = {$urandom, $urandom};
        2: now_t += cur_cool;
        default: now_t -= $urandom_range(1, 100);
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgIdxCooldown;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    gesture_i = GestNone;
    hand_present_i = 1'b0;
    now_ms_i = '0;
    hold_req = 0;
    frames_sent = 0;
    step_max = 20;
    now_t = '0;
    cur_cool = CooldownRst;
    cur_absent = AbsentRst;
    snd_idle_pct = 9;
    rcv_idle_pct = 63;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed frames on reset settings (cooldown 1000, three absent frames)
    send_frame(GestNone, 1'b1, 64'd0);             // idle none: all zero
    send_frame(GestFist, 1'b1, 64'd100);           // fist needs four
    send_frame(GestFist, 1'b1, 64'd110);
    send_frame(GestFist, 1'b1, 64'd120);
    send_frame(GestFist, 1'b1, 64'd130);           // trigger fist
    send_frame(GestFist, 1'b1, 64'd140);           // held class again: hold
    send_frame(GestOk, 1'b1, 64'd200);             // other class inside cooldown: hold
    send_frame(GestNone, 1'b0, 64'd300);           // latched, hand gone
    send_frame(GestNone, 1'b0, 64'd400);
    send_frame(GestSpare, 1'b0, 64'd2000);         // release, then class 7 voted hand absent
    send_frame(GestSpare, 1'b1, 64'd2010);
    send_frame(GestSpare, 1'b1, 64'd2020);         // trigger class 7 on three votes
    send_frame(GestOk, 1'b1, 64'd3020);            // switch exactly at cooldown
    send_frame(GestNone, 1'b1, 64'd3030);          // not latched none: candidate clears
    send_frame(GestFive, 1'b1, 64'd3040);
    send_frame(GestFive, 1'b1, 64'd3050);
    send_frame(GestFive, 1'b1, 64'd3060);          // trigger five
    send_frame(GestTwo, 1'b1, 64'd3059);           // time went back: difference wraps
    send_frame(GestTwo, 1'b1, 64'd3070);
    send_frame(GestTwo, 1'b1, 64'd3080);
    send_frame(GestTwo, 1'b1, 64'd3090);           // trigger two
    send_frame(GestFour, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(GestFour, 1'b1, 64'd0);
    send_frame(GestFour, 1'b1, 64'd1);             // trigger four across the wrap
    send_frame(GestThree, 1'b1, 64'd2);            // inside cooldown: hold, votes four
    now_t = 64'd10;

    // low extremes: no cooldown, one absent frame releases
    drain();
    set_config('0, 8'd1);
    stop_at = frames_sent + 350;
    while (frames_sent < stop_at) random_burst();
    next_frame(GestNone, 1'b0);                    // leaves the filter unlatched

    // high extremes: longest cooldown, 255 absent frames
    drain();
    set_config(32'hFFFF_FFFF, 8'd255);
    repeat (4) next_frame(GestFist, 1'b1);
    now_t += 64'h2_0000_0000;
    repeat (256) next_frame(GestNone, 1'b0);       // absent count saturates, then releases
    stop_at = frames_sent + 250;
    while (frames_sent < stop_at) random_burst();

    // swap idling, mid settings, one long output hold-off while frames keep coming
    snd_idle_pct = 63;
    rcv_idle_pct = 9;
    drain();
    set_config(CoolW'($urandom_range(10, 300)), AbsentW'($urandom_range(1, 6)));
    step_max = 40;
    stop_at = frames_sent + 150;
    while (frames_sent < stop_at) random_burst();
    hold_req = 150;
    stop_at = frames_sent + 200;
    while (frames_sent < stop_at) random_burst();

    // zero absent threshold: one absent frame after cooldown releases
    drain();
    set_config(32'd50, 8'd0);
    step_max = 20;
    stop_at = frames_sent + 200;
    while (frames_sent < stop_at) random_burst();

    // no idling on either side, with a full pause halfway
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    drain();
    set_config(CoolW'($urandom_range(60, 150)), 8'd2);
    stop_at = frames_sent + 175;
    while (frames_sent < stop_at) random_burst();
    drain();
    stop_at = frames_sent + 175;
    while (frames_sent < stop_at) random_burst();

    drain();
    repeat (10) @(negedge clk_i);
    $display("sent %0d frames, checked %0d results, %0d gestures triggered",
             frames_sent, checked, triggers);
    $display("cooldown 0 to 2^32-1, absence threshold 0 to 255, wrapped time, three idle mixes");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
